@@ design/gsalu_pkg.sv @@
// Scalar ALU package: command codes, compare selectors and transaction types.
// Used by gsalu_alu, gpu_scalar_alu_with_scc and gsalu_chk. No dependencies.
package gsalu_pkg;

  typedef enum logic [5:0] {
    CMD_MOV_B32          = 6'd0,
    CMD_ADD_U32          = 6'd1,
    CMD_ADD_I32          = 6'd2,
    CMD_ADDC_U32         = 6'd3,
    CMD_SUB_U32          = 6'd4,
    CMD_SUB_I32          = 6'd5,
    CMD_MUL_I32          = 6'd6,
    CMD_AND_B32          = 6'd7,
    CMD_NAND_B32         = 6'd8,
    CMD_ANDN2_B32        = 6'd9,
    CMD_OR_B32           = 6'd10,
    CMD_XOR_B32          = 6'd11,
    CMD_LSHL_B32         = 6'd12,
    CMD_LSHR_B32         = 6'd13,
    CMD_ASHR_I32         = 6'd14,
    CMD_BFE_U32          = 6'd15,
    CMD_BFM_B32          = 6'd16,
    CMD_BREV_B32         = 6'd17,
    CMD_MIN_U32          = 6'd18,
    CMD_MIN_I32          = 6'd19,
    CMD_MAX_U32          = 6'd20,
    CMD_MAX_I32          = 6'd21,
    CMD_ABSDIFF_I32      = 6'd22,
    CMD_CSELECT_B32      = 6'd23,
    CMD_CMP_EQ_I32       = 6'd24,
    CMD_CMP_LG_I32       = 6'd25,
    CMD_CMP_GT_I32       = 6'd26,
    CMD_CMP_GE_I32       = 6'd27,
    CMD_CMP_LT_I32       = 6'd28,
    CMD_CMP_LE_I32       = 6'd29,
    CMD_CMP_EQ_U32       = 6'd30,
    CMD_CMP_LG_U32       = 6'd31,
    CMD_CMP_GT_U32       = 6'd32,
    CMD_CMP_GE_U32       = 6'd33,
    CMD_CMP_LT_U32       = 6'd34,
    CMD_CMP_LE_U32       = 6'd35,
    CMD_CMPK_EQ_I32      = 6'd36,
    CMD_CMPK_LG_I32      = 6'd37,
    CMD_CMPK_GT_I32      = 6'd38,
    CMD_CMPK_GE_I32      = 6'd39,
    CMD_CMPK_LT_I32      = 6'd40,
    CMD_CMPK_LE_I32      = 6'd41,
    CMD_CMPK_EQ_U32      = 6'd42,
    CMD_CMPK_LG_U32      = 6'd43,
    CMD_CMPK_GT_U32      = 6'd44,
    CMD_CMPK_GE_U32      = 6'd45,
    CMD_CMPK_LT_U32      = 6'd46,
    CMD_CMPK_LE_U32      = 6'd47,
    CMD_MOVK_I32         = 6'd48,
    CMD_ADDK_I32         = 6'd49,
    CMD_MULK_I32         = 6'd50,
    CMD_MOV_B64          = 6'd51,
    CMD_AND_B64          = 6'd52,
    CMD_NAND_B64         = 6'd53,
    CMD_ANDN2_B64        = 6'd54,
    CMD_OR_B64           = 6'd55,
    CMD_NOR_B64          = 6'd56,
    CMD_XOR_B64          = 6'd57,
    CMD_XNOR_B64         = 6'd58,
    CMD_ORN2_B64         = 6'd59,
    CMD_NOT_B64          = 6'd60,
    CMD_CSELECT_B64      = 6'd61,
    CMD_AND_SAVEEXEC_B64 = 6'd62,
    CMD_INVALID          = 6'd63
  } cmd_t;

  // Compare selector, order within each compare group
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_LG = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_LT = 3'd4;
  localparam logic [2:0] CMP_LE = 3'd5;

  localparam logic [31:0] SIGN32   = 32'h8000_0000;
  localparam logic [4:0]  BFE_WMAX = 5'd31;

  typedef struct packed {
    logic [5:0]         command;
    logic [63:0]        src_a;
    logic [63:0]        src_b;
    logic signed [15:0] imm16;
    logic               dest_is_exec;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result;
    logic        writes_dest;
    logic        scc_out;
    logic [63:0] exec_out;
    logic        unsupported;
  } out_item_t;

  // Architectural flags carried between instructions
  typedef struct packed {
    logic        scc;
    logic [63:0] exec;
  } flags_t;

endpackage

@@ design/gsalu_alu.sv @@
// Scalar ALU datapath: one instruction against the current SCC/EXEC, purely combinational.
// Depends on gsalu_pkg.
module gsalu_alu (
  input  gsalu_pkg::in_item_t  item,
  input  gsalu_pkg::flags_t    flags,
  output gsalu_pkg::out_item_t res
);

  logic [31:0] a, b, ksext, kzext;
  logic [4:0]  sh;
  logic [6:0]  bfe_w;
  logic [31:0] bfe_mask;
  logic [32:0] add_ab, addc_ab, addk_s;
  logic [31:0] sub_ab, absd, brev;
  logic [31:0] mul_b, prod;
  logic [5:0]  cmp_off;
  logic [2:0]  cmp_sel;
  logic        cmp_sgn;
  logic [31:0] cmp_y, cmp_xs, cmp_ys;
  logic        cmp_eq, cmp_lt, cmp_gt, cmp_res;
  logic [31:0] d;
  logic [63:0] d64, ex_n;
  logic        wide, wd, unsup, setnz, scc_n;
  gsalu_pkg::cmd_t cmd;

  assign cmd   = gsalu_pkg::cmd_t'(item.command);
  assign a     = item.src_a[31:0];
  assign b     = item.src_b[31:0];
  assign sh    = b[4:0];
  assign ksext = {{16{item.imm16[15]}}, item.imm16};
  assign kzext = {16'd0, item.imm16};

  assign add_ab  = {1'b0, a} + {1'b0, b};
  assign addc_ab = {1'b0, a} + {1'b0, b} + {32'd0, flags.scc};
  assign addk_s  = {1'b0, a} + {1'b0, ksext};
  assign sub_ab  = a - b;
  assign absd    = sub_ab[31] ? (32'd0 - sub_ab) : sub_ab;

  // width of 32 or more keeps everything above the offset
  assign bfe_w    = b[22:16];
  assign bfe_mask = (bfe_w > {2'd0, gsalu_pkg::BFE_WMAX}) ? '1
                    : ((32'd1 << bfe_w[4:0]) - 32'd1);

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      brev[i] = a[31-i];
    end
  end

  // one 32x32 multiplier shared by MUL and MULK, low half only
  assign mul_b = (cmd == gsalu_pkg::CMD_MULK_I32) ? ksext : b;
  assign prod  = a * mul_b;

  // shared comparator; also serves min/max
  always_comb begin
    cmp_off = 6'd0;
    cmp_sgn = 1'b0;
    cmp_y   = b;
    case (cmd) inside
      [gsalu_pkg::CMD_CMP_EQ_I32:gsalu_pkg::CMD_CMP_LE_I32]: begin
        cmp_off = 6'(cmd - gsalu_pkg::CMD_CMP_EQ_I32);
        cmp_sgn = 1'b1;
      end
      [gsalu_pkg::CMD_CMP_EQ_U32:gsalu_pkg::CMD_CMP_LE_U32]: begin
        cmp_off = 6'(cmd - gsalu_pkg::CMD_CMP_EQ_U32);
      end
      [gsalu_pkg::CMD_CMPK_EQ_I32:gsalu_pkg::CMD_CMPK_LE_I32]: begin
        cmp_off = 6'(cmd - gsalu_pkg::CMD_CMPK_EQ_I32);
        cmp_sgn = 1'b1;
        cmp_y   = ksext;
      end
      [gsalu_pkg::CMD_CMPK_EQ_U32:gsalu_pkg::CMD_CMPK_LE_U32]: begin
        cmp_off = 6'(cmd - gsalu_pkg::CMD_CMPK_EQ_U32);
        cmp_y   = kzext;
      end
      gsalu_pkg::CMD_MIN_I32, gsalu_pkg::CMD_MAX_I32: begin
        cmp_sgn = 1'b1;
      end
      default: begin
        cmp_sgn = 1'b0;
      end
    endcase
  end

  assign cmp_sel = cmp_off[2:0];
  assign cmp_xs  = cmp_sgn ? (a ^ gsalu_pkg::SIGN32) : a;
  assign cmp_ys  = cmp_sgn ? (cmp_y ^ gsalu_pkg::SIGN32) : cmp_y;
  assign cmp_eq  = (cmp_xs == cmp_ys);
  assign cmp_lt  = (cmp_xs < cmp_ys);
  assign cmp_gt  = !cmp_lt && !cmp_eq;

  always_comb begin
    unique case (cmp_sel)
      gsalu_pkg::CMP_EQ: cmp_res = cmp_eq;
      gsalu_pkg::CMP_LG: cmp_res = !cmp_eq;
      gsalu_pkg::CMP_GT: cmp_res = cmp_gt;
      gsalu_pkg::CMP_GE: cmp_res = !cmp_lt;
      gsalu_pkg::CMP_LT: cmp_res = cmp_lt;
      default:           cmp_res = cmp_lt || cmp_eq;
    endcase
  end

  always_comb begin
    d     = '0;
    d64   = '0;
    wide  = 1'b0;
    wd    = 1'b1;
    unsup = 1'b0;
    setnz = 1'b0;
    scc_n = flags.scc;
    ex_n  = flags.exec;
    unique case (cmd) inside
      gsalu_pkg::CMD_MOV_B32:     d = a;
      gsalu_pkg::CMD_ADD_U32:     begin d = add_ab[31:0]; scc_n = add_ab[32]; end
      gsalu_pkg::CMD_ADD_I32: begin
        d     = add_ab[31:0];
        scc_n = (a[31] ^ add_ab[31]) & (b[31] ^ add_ab[31]);
      end
      gsalu_pkg::CMD_ADDC_U32:    begin d = addc_ab[31:0]; scc_n = addc_ab[32]; end
      gsalu_pkg::CMD_SUB_U32:     begin d = sub_ab; scc_n = (b > a); end
      gsalu_pkg::CMD_SUB_I32: begin
        d     = sub_ab;
        scc_n = (a[31] ^ b[31]) & (a[31] ^ sub_ab[31]);
      end
      gsalu_pkg::CMD_MUL_I32,
      gsalu_pkg::CMD_MULK_I32:    d = prod;
      gsalu_pkg::CMD_AND_B32:     begin d = a & b;    setnz = 1'b1; end
      gsalu_pkg::CMD_NAND_B32:    begin d = ~(a & b); setnz = 1'b1; end
      gsalu_pkg::CMD_ANDN2_B32:   begin d = a & ~b;   setnz = 1'b1; end
      gsalu_pkg::CMD_OR_B32:      begin d = a | b;    setnz = 1'b1; end
      gsalu_pkg::CMD_XOR_B32:     begin d = a ^ b;    setnz = 1'b1; end
      gsalu_pkg::CMD_LSHL_B32:    begin d = a << sh;  setnz = 1'b1; end
      gsalu_pkg::CMD_LSHR_B32:    begin d = a >> sh;  setnz = 1'b1; end
      gsalu_pkg::CMD_ASHR_I32: begin
        d     = 32'($signed(a) >>> sh);
        setnz = 1'b1;
      end
      gsalu_pkg::CMD_BFE_U32:     begin d = (a >> sh) & bfe_mask; setnz = 1'b1; end
      gsalu_pkg::CMD_BFM_B32:     d = ((32'd1 << a[4:0]) - 32'd1) << sh;
      gsalu_pkg::CMD_BREV_B32:    d = brev;
      gsalu_pkg::CMD_MIN_U32,
      gsalu_pkg::CMD_MIN_I32: begin
        d     = cmp_lt ? a : b;
        scc_n = cmp_lt || cmp_eq;
      end
      gsalu_pkg::CMD_MAX_U32,
      gsalu_pkg::CMD_MAX_I32: begin
        d     = cmp_gt ? a : b;
        scc_n = cmp_gt || cmp_eq;
      end
      gsalu_pkg::CMD_ABSDIFF_I32: begin d = absd; setnz = 1'b1; end
      gsalu_pkg::CMD_CSELECT_B32: d = flags.scc ? a : b;
      [gsalu_pkg::CMD_CMP_EQ_I32:gsalu_pkg::CMD_CMPK_LE_U32]: begin
        scc_n = cmp_res;
        wd    = 1'b0;
      end
      gsalu_pkg::CMD_MOVK_I32:    d = ksext;
      gsalu_pkg::CMD_ADDK_I32: begin
        d     = addk_s[31:0];
        scc_n = (a[31] ^ addk_s[31]) & (ksext[31] ^ addk_s[31]);
      end
      gsalu_pkg::CMD_MOV_B64:     begin wide = 1'b1; d64 = item.src_a; end
      gsalu_pkg::CMD_AND_B64:     begin wide = 1'b1; d64 = item.src_a & item.src_b; end
      gsalu_pkg::CMD_NAND_B64:    begin wide = 1'b1; d64 = ~(item.src_a & item.src_b); end
      gsalu_pkg::CMD_ANDN2_B64:   begin wide = 1'b1; d64 = item.src_a & ~item.src_b; end
      gsalu_pkg::CMD_OR_B64:      begin wide = 1'b1; d64 = item.src_a | item.src_b; end
      gsalu_pkg::CMD_NOR_B64:     begin wide = 1'b1; d64 = ~(item.src_a | item.src_b); end
      gsalu_pkg::CMD_XOR_B64:     begin wide = 1'b1; d64 = item.src_a ^ item.src_b; end
      gsalu_pkg::CMD_XNOR_B64:    begin wide = 1'b1; d64 = ~(item.src_a ^ item.src_b); end
      gsalu_pkg::CMD_ORN2_B64:    begin wide = 1'b1; d64 = item.src_a | ~item.src_b; end
      gsalu_pkg::CMD_NOT_B64:     begin wide = 1'b1; d64 = ~item.src_a; end
      gsalu_pkg::CMD_CSELECT_B64: begin
        wide = 1'b1;
        d64  = flags.scc ? item.src_a : item.src_b;
      end
      gsalu_pkg::CMD_AND_SAVEEXEC_B64: begin
        wide  = 1'b1;
        d64   = flags.exec;
        ex_n  = flags.exec & item.src_a;
        scc_n = |(flags.exec & item.src_a);
      end
      default: begin
        unsup = 1'b1;
        wd    = 1'b0;
      end
    endcase

    if (setnz) begin
      scc_n = |d;
    end
    if (!wide) begin
      d64 = {32'd0, d};
    end else if ((cmd != gsalu_pkg::CMD_MOV_B64) && (cmd != gsalu_pkg::CMD_CSELECT_B64)
                 && (cmd != gsalu_pkg::CMD_AND_SAVEEXEC_B64)) begin
      scc_n = |d64;
    end
    // mask move / and forms may target EXEC instead of an SGPR pair
    if (item.dest_is_exec && ((cmd == gsalu_pkg::CMD_MOV_B64) || (cmd == gsalu_pkg::CMD_AND_B64)
        || (cmd == gsalu_pkg::CMD_NAND_B64) || (cmd == gsalu_pkg::CMD_ANDN2_B64))) begin
      ex_n = d64;
      wd   = 1'b0;
    end
  end

  assign res.result      = (wd || wide) ? d64 : 64'd0;
  assign res.writes_dest = wd;
  assign res.scc_out     = scc_n;
  assign res.exec_out    = ex_n;
  assign res.unsupported = unsup;

endmodule

@@ design/gpu_scalar_alu_with_scc.sv @@
// Scalar ALU top level: input register, ALU datapath, result register, SCC/EXEC state.
// Depends on gsalu_pkg and gsalu_alu.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    gsalu_pkg::in_item_t  in_data
//   out_     output     out_valid / out_ready  gsalu_pkg::out_item_t out_data
//
// Pipe: two stages. An accepted transaction is evaluated in the input register and moves to
//   the result register when that is free or emptying; one transaction per cycle sustained
//   while out_ready is high. The ALU pass (32x32 multiplier path) sets the clock limit.
// SCC and EXEC update when an item enters the result register, so the next item
//   always sees the flags left by its predecessor.
// Reset: synchronous, active low; both stages empty, SCC = 0, EXEC = all ones.
// Stalls: a held result blocks the input register only when both are full; in_ready
//   drops only while out_valid is high and out_ready is low.
module gpu_scalar_alu_with_scc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gsalu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gsalu_pkg::out_item_t out_data
);

  logic                 s1_valid_r, s1_valid_nxt;
  gsalu_pkg::in_item_t  s1_item_r;
  logic                 out_valid_r, out_valid_nxt;
  gsalu_pkg::out_item_t out_item_r;
  gsalu_pkg::flags_t    flags_r, flags_nxt;
  gsalu_pkg::out_item_t alu_res;
  logic                 s2_load;

  gsalu_alu u_alu (
    .item  (s1_item_r),
    .flags (flags_r),
    .res   (alu_res)
  );

  // result register free, or being emptied this cycle
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    flags_nxt     = flags_r;
    if (s2_load) begin
      flags_nxt.scc  = alu_res.scc_out;
      flags_nxt.exec = alu_res.exec_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      flags_r.scc  <= 1'b0;
      flags_r.exec <= '1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s2_load) begin
      out_item_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

@@ design/gsalu_chk.sv @@
// Port-level checker for the scalar ALU, bound into gpu_scalar_alu_with_scc.
// Depends on gsalu_pkg.
module gsalu_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input gsalu_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input gsalu_pkg::out_item_t out_data
);

  logic        seen_r;
  logic        last_scc_r;
  logic [63:0] last_exec_r;

  // flags shown by the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      last_scc_r  <= 1'b0;
      last_exec_r <= '1;
    end else if (out_valid && out_ready) begin
      seen_r      <= 1'b1;
      last_scc_r  <= out_data.scc_out;
      last_exec_r <= out_data.exec_out;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unsupported |-> !out_data.writes_dest && out_data.result == 64'd0)
    else $error("unsupported command produced a write");

  a_unsup_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unsupported |->
      out_data.scc_out == last_scc_r && out_data.exec_out == last_exec_r)
    else $error("unsupported command altered SCC or EXEC");

  // seen_r only qualifies history; reset values stand in before the first result
  a_first_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> last_scc_r == 1'b0 && last_exec_r == '1)
    else $error("flag history not at reset value");

endmodule

bind gpu_scalar_alu_with_scc gsalu_chk u_gsalu_chk (.*);

@@ sim/gpu_scalar_alu_with_scc_test.sv @@
// Self-checking testbench for gpu_scalar_alu_with_scc: directed table plus random transactions,
// checked field by field against typed-in results or an in-bench model (ALU, SCC, EXEC).
// Depends on gsalu_pkg (command codes, compare selectors, transaction structs) and the block.
module gpu_scalar_alu_with_scc_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 12;
  localparam int N_RANDOM     = 1875;  // random transactions after the directed table
  localparam int LONG_HOLD    = 80;    // receiver hold-off, long enough to back up both stages
  localparam int DRAIN_CYCLES = 8;     // idle cycles at the end, after every result is back
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either channel
  localparam int MAX_SHOWN    = 10;

  // One row of the directed table. Where typed is set, want holds the result read straight
  // off the spec; otherwise the model supplies it.
  typedef struct {
    gsalu_pkg::in_item_t  stim;
    bit                   typed;
    gsalu_pkg::out_item_t want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  gsalu_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  gsalu_pkg::out_item_t out_data;

  // Model state: SCC and EXEC as they stand after the last accepted transaction
  logic        pred_scc;
  logic [63:0] pred_exec;

  gsalu_pkg::out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        quiet_cycles   = 0;

  // Receiver state
  int          rx_cycle;
  int          hold_left;
  logic [15:0] ready_pat;

  always #(CLK_PERIOD / 2) clk = ~clk;

  gpu_scalar_alu_with_scc u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------------------
  // Model of one instruction. Updates the SCC/EXEC copies and returns the result transaction.
  // ---------------------------------------------------------------------------------------
  function automatic gsalu_pkg::out_item_t execute_scalar(input gsalu_pkg::in_item_t it,
                                                          inout logic scc_st,
                                                          inout logic [63:0] exec_st);
    gsalu_pkg::cmd_t      op;
    logic [31:0] a, b, d, kx, rhs, msk, xa, xb;
    logic [63:0] d64, ex;
    logic [32:0] sum;
    logic [4:0]  cnt;
    logic [6:0]  wid;
    logic        scc, wide, wd, unsup, nz, sg, a_less, a_more, pick_a;
    logic [2:0]  sel;
    int          off, grp;
    gsalu_pkg::out_item_t o;

    op    = gsalu_pkg::cmd_t'(it.command);
    a     = it.src_a[31:0];
    b     = it.src_b[31:0];
    kx    = {{16{it.imm16[15]}}, it.imm16};
    cnt   = b[4:0];            // only the low five bits count
    wid   = b[22:16];
    scc   = scc_st;
    ex    = exec_st;
    d     = '0;
    d64   = '0;
    wide  = 1'b0;
    wd    = 1'b1;
    unsup = 1'b0;
    nz    = 1'b0;

    case (op)
      gsalu_pkg::CMD_MOV_B32: d = a;
      gsalu_pkg::CMD_ADD_U32: begin
        sum = {1'b0, a} + {1'b0, b};
        d   = sum[31:0];
        scc = sum[32];
      end
      gsalu_pkg::CMD_ADD_I32: begin
        d   = a + b;
        scc = (a[31] == b[31]) && (d[31] != a[31]);
      end
      gsalu_pkg::CMD_ADDC_U32: begin
        sum = {1'b0, a} + {1'b0, b} + {32'b0, scc_st};
        d   = sum[31:0];
        scc = sum[32];
      end
      gsalu_pkg::CMD_SUB_U32: begin
        d   = a - b;
        scc = b > a;
      end
      gsalu_pkg::CMD_SUB_I32: begin
        d   = a - b;
        scc = (a[31] != b[31]) && (d[31] != a[31]);
      end
      gsalu_pkg::CMD_MUL_I32:   d = a * b;
      gsalu_pkg::CMD_AND_B32:   begin d = a & b;    nz = 1'b1; end
      gsalu_pkg::CMD_NAND_B32:  begin d = ~(a & b); nz = 1'b1; end
      gsalu_pkg::CMD_ANDN2_B32: begin d = a & ~b;   nz = 1'b1; end
      gsalu_pkg::CMD_OR_B32:    begin d = a | b;    nz = 1'b1; end
      gsalu_pkg::CMD_XOR_B32:   begin d = a ^ b;    nz = 1'b1; end
      gsalu_pkg::CMD_LSHL_B32:  begin d = a << cnt; nz = 1'b1; end
      gsalu_pkg::CMD_LSHR_B32:  begin d = a >> cnt; nz = 1'b1; end
      gsalu_pkg::CMD_ASHR_I32:  begin d = $signed(a) >>> cnt; nz = 1'b1; end
      gsalu_pkg::CMD_BFE_U32: begin
        // widths of 32 and up keep everything above the offset
        msk = (wid >= 7'd32) ? 32'hFFFF_FFFF : ((32'd1 << wid) - 32'd1);
        d   = (a >> cnt) & msk;
        nz  = 1'b1;
      end
      gsalu_pkg::CMD_BFM_B32: d = ((32'd1 << a[4:0]) - 32'd1) << cnt;
      gsalu_pkg::CMD_BREV_B32: begin
        for (int i = 0; i < 32; i++) d[i] = a[31 - i];
      end
      gsalu_pkg::CMD_MIN_U32, gsalu_pkg::CMD_MIN_I32,
      gsalu_pkg::CMD_MAX_U32, gsalu_pkg::CMD_MAX_I32: begin
        sg     = (op == gsalu_pkg::CMD_MIN_I32) || (op == gsalu_pkg::CMD_MAX_I32);
        a_less = sg ? ($signed(a) < $signed(b)) : (a < b);
        a_more = sg ? ($signed(a) > $signed(b)) : (a > b);
        pick_a = (op == gsalu_pkg::CMD_MIN_U32 || op == gsalu_pkg::CMD_MIN_I32) ? a_less
                                                                               : a_more;
        d      = pick_a ? a : b;
        scc    = (d == a);
      end
      gsalu_pkg::CMD_ABSDIFF_I32: begin
        d = a - b;
        if (d[31]) d = -d;       // most negative value wraps back onto itself
        nz = 1'b1;
      end
      gsalu_pkg::CMD_CSELECT_B32: d = scc_st ? a : b;
      gsalu_pkg::CMD_MOVK_I32:    d = kx;
      gsalu_pkg::CMD_ADDK_I32: begin
        d   = a + kx;
        scc = (a[31] == kx[31]) && (d[31] != a[31]);
      end
      gsalu_pkg::CMD_MULK_I32:   d = a * kx;
      gsalu_pkg::CMD_MOV_B64:    begin wide = 1'b1; d64 = it.src_a; end
      gsalu_pkg::CMD_AND_B64: begin
        wide = 1'b1; d64 = it.src_a & it.src_b;    scc = d64 != 0;
      end
      gsalu_pkg::CMD_NAND_B64: begin
        wide = 1'b1; d64 = ~(it.src_a & it.src_b); scc = d64 != 0;
      end
      gsalu_pkg::CMD_ANDN2_B64: begin
        wide = 1'b1; d64 = it.src_a & ~it.src_b;   scc = d64 != 0;
      end
      gsalu_pkg::CMD_OR_B64: begin
        wide = 1'b1; d64 = it.src_a | it.src_b;    scc = d64 != 0;
      end
      gsalu_pkg::CMD_NOR_B64: begin
        wide = 1'b1; d64 = ~(it.src_a | it.src_b); scc = d64 != 0;
      end
      gsalu_pkg::CMD_XOR_B64: begin
        wide = 1'b1; d64 = it.src_a ^ it.src_b;    scc = d64 != 0;
      end
      gsalu_pkg::CMD_XNOR_B64: begin
        wide = 1'b1; d64 = ~(it.src_a ^ it.src_b); scc = d64 != 0;
      end
      gsalu_pkg::CMD_ORN2_B64: begin
        wide = 1'b1; d64 = it.src_a | ~it.src_b;   scc = d64 != 0;
      end
      gsalu_pkg::CMD_NOT_B64: begin
        wide = 1'b1; d64 = ~it.src_a;              scc = d64 != 0;
      end
      gsalu_pkg::CMD_CSELECT_B64: begin wide = 1'b1; d64 = scc_st ? it.src_a : it.src_b; end
      gsalu_pkg::CMD_AND_SAVEEXEC_B64: begin
        wide = 1'b1;
        d64  = exec_st;
        ex   = exec_st & it.src_a;
        scc  = ex != 0;
      end
      gsalu_pkg::CMD_INVALID: begin
        unsup = 1'b1;
        wd    = 1'b0;
      end
      default: begin
        // compare groups: register signed, register unsigned, imm signed, imm unsigned
        off = int'(op) - int'(gsalu_pkg::CMD_CMP_EQ_I32);
        grp = off / 6;
        sel = 3'(off % 6);
        rhs = (grp < 2) ? b : (grp == 2) ? kx : {16'b0, it.imm16};
        xa  = (grp % 2 == 0) ? (a ^ gsalu_pkg::SIGN32) : a;
        xb  = (grp % 2 == 0) ? (rhs ^ gsalu_pkg::SIGN32) : rhs;
        case (sel)
          gsalu_pkg::CMP_EQ: scc = xa == xb;
          gsalu_pkg::CMP_LG: scc = xa != xb;
          gsalu_pkg::CMP_GT: scc = xa > xb;
          gsalu_pkg::CMP_GE: scc = xa >= xb;
          gsalu_pkg::CMP_LT: scc = xa < xb;
          default:           scc = xa <= xb;
        endcase
        wd = 1'b0;
      end
    endcase

    if (nz) scc = d != 0;
    if (!wide) d64 = {32'b0, d};
    // mask move and AND forms may target EXEC; the result field still shows the value
    if (wide && it.dest_is_exec && op >= gsalu_pkg::CMD_MOV_B64
        && op <= gsalu_pkg::CMD_ANDN2_B64) begin
      ex = d64;
      wd = 1'b0;
    end

    scc_st  = scc;
    exec_st = ex;

    o.result      = (wd || wide) ? d64 : '0;
    o.writes_dest = wd;
    o.scc_out     = scc;
    o.exec_out    = ex;
    o.unsupported = unsup;
    return o;
  endfunction

  // Directed rows: pr leaves the result to the model, tr carries a typed-in result
  function automatic dir_row_t pr(gsalu_pkg::cmd_t c, logic [63:0] a, logic [63:0] b,
                                  logic [15:0] k, logic x);
    dir_row_t r;
    r.stim  = '{command: c, src_a: a, src_b: b, imm16: k, dest_is_exec: x};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t tr(gsalu_pkg::cmd_t c, logic [63:0] a, logic [63:0] b,
                                  logic [15:0] k, logic x, logic [63:0] res, logic wd,
                                  logic s, logic [63:0] ex, logic un);
    dir_row_t r;
    r       = pr(c, a, b, k, x);
    r.typed = 1'b1;
    r.want  = '{result: res, writes_dest: wd, scc_out: s, exec_out: ex, unsupported: un};
    return r;
  endfunction

  // Operand mix: corner values often enough to hit carries, signs and empty masks
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {32'($urandom), 32'h8000_0000};
      3:       return {32'($urandom), 32'h7FFF_FFFF};
      4:       return 64'($urandom_range(0, 40));
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender helpers. Every task is entered and left on a rising edge, and in_valid gets at
  // most one nonblocking write per edge.
  // ---------------------------------------------------------------------------------------

  // Offer one transaction and hold it until taken; the expectation is queued on acceptance.
  task automatic send_item(input gsalu_pkg::in_item_t it, input bit typed,
                           input gsalu_pkg::out_item_t want);
    gsalu_pkg::out_item_t got;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = execute_scalar(it, pred_scc, pred_exec);
    pending_results.push_back(typed ? want : got);
  endtask

  // Bursts of random length; between bursts the sender idles for a few cycles, or not at all.
  task automatic sender_gap();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
    end
    burst_left--;
  endtask

  // Stop offering until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t            table_rows[$];
    gsalu_pkg::in_item_t it;
    logic [15:0]         k;

    // Reset state is SCC = 0 and EXEC = all ones; the typed rows rely on that and on
    // their own order, and all of them leave EXEC alone.
    table_rows.push_back(tr(gsalu_pkg::CMD_MOV_B32, '1, '0, 16'h0000, 1'b1,
                            64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, '1, 1'b0));
    table_rows.push_back(tr(gsalu_pkg::CMD_INVALID, '1, '1, 16'h7FFF, 1'b1,
                            '0, 1'b0, 1'b0, '1, 1'b1));
    // carry out of the top bit
    table_rows.push_back(tr(gsalu_pkg::CMD_ADD_U32, '1, 64'h1, 16'h0000, 1'b0,
                            '0, 1'b1, 1'b1, '1, 1'b0));
    // carry in from SCC and carry out again
    table_rows.push_back(tr(gsalu_pkg::CMD_ADDC_U32, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 16'h0000,
                            1'b0, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, '1, 1'b0));
    // compare sees only the low halves; no register write
    table_rows.push_back(tr(gsalu_pkg::CMD_CMP_EQ_U32, 64'hAAAA_AAAA_0000_0000,
                            64'h5555_5555_0000_0000, 16'h0000, 1'b0,
                            '0, 1'b0, 1'b1, '1, 1'b0));
    // absolute difference of the most negative value
    table_rows.push_back(tr(gsalu_pkg::CMD_ABSDIFF_I32, 64'h8000_0000, '0, 16'h0000, 1'b0,
                            64'h0000_0000_8000_0000, 1'b1, 1'b1, '1, 1'b0));
    // bitfield of width zero
    table_rows.push_back(tr(gsalu_pkg::CMD_BFE_U32, '1, 64'h3, 16'h0000, 1'b0,
                            '0, 1'b1, 1'b0, '1, 1'b0));
    // borrow
    table_rows.push_back(tr(gsalu_pkg::CMD_SUB_U32, '0, 64'h1, 16'h0000, 1'b0,
                            64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, '1, 1'b0));
    // model-checked rows
    table_rows.push_back(pr(gsalu_pkg::CMD_BFE_U32, '1, 64'h007F_0004, 16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_LSHL_B32, 64'h1, 64'hFFFF_FFFF_FFFF_FFE5,
                            16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_ASHR_I32, 64'h8000_0000, 64'd31, 16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_MOVK_I32, '1, '1, 16'h8000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_ADDK_I32, 64'h7FFF_FFFF, '0, 16'h0001, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_MULK_I32, '1, '0, 16'h7FFF, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_CMPK_LT_I32, 64'h8000_0000, '0, 16'hFFFF, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_CMPK_GT_U32, 64'h0000_FFFF, '0, 16'hFFFF, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_MAX_I32, 64'h7FFF_FFFF, 64'h8000_0000, 16'h0000,
                            1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_MIN_U32, '1, '0, 16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_BFM_B32, 64'd31, 64'd31, 16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_BREV_B32, 64'h1, '0, 16'h0000, 1'b0));
    // EXEC as destination: clear it, save-exec on an empty mask, restore it, then save-exec and ANDN2
    table_rows.push_back(pr(gsalu_pkg::CMD_MOV_B64, '0, '1, 16'h0000, 1'b1));
    table_rows.push_back(pr(gsalu_pkg::CMD_AND_SAVEEXEC_B64, '1, '0, 16'h0000, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_MOV_B64, '1, '0, 16'h0000, 1'b1));
    table_rows.push_back(pr(gsalu_pkg::CMD_AND_SAVEEXEC_B64, 64'h8000_0000_0000_0001, '0,
                            16'h0, 1'b0));
    table_rows.push_back(pr(gsalu_pkg::CMD_ANDN2_B64, '1, 64'h0F0F_0F0F_0F0F_0F0F, 16'h0000,
                            1'b1));
    // EXEC flag ignored here
    table_rows.push_back(pr(gsalu_pkg::CMD_OR_B64, '0, '0, 16'h0000, 1'b1));
    table_rows.push_back(pr(gsalu_pkg::CMD_CSELECT_B64, '1, 64'h1234_5678_9ABC_DEF0, 16'h0000,
                            1'b0));

    pred_scc  = 1'b0;
    pred_exec = '1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      sender_gap();
      send_item(table_rows[i].stim, table_rows[i].typed, table_rows[i].want);
    end
    wait_drained();

    // Random part: uniform over all commands, corner-heavy operands
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) wait_drained();
      it.command = 6'($urandom_range(int'(gsalu_pkg::CMD_MOV_B32),
                                     int'(gsalu_pkg::CMD_INVALID)));
      it.src_a   = pick_operand();
      it.src_b   = ($urandom_range(0, 7) == 0) ? it.src_a : pick_operand();
      case ($urandom_range(0, 9))
        0:       k = 16'h8000;
        1:       k = 16'h7FFF;
        2:       k = 16'hFFFF;
        3:       k = 16'h0000;
        4:       k = it.src_a[15:0];   // lets the immediate compares hit equality
        default: k = 16'($urandom);
      endcase
      it.imm16        = k;
      it.dest_is_exec = 1'($urandom);
      sender_gap();
      send_item(it, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: ready follows a random 16-bit pattern, redrawn as the run goes on, sometimes all
  // ones. Twice it holds ready low while the sender keeps going, so both pipe stages fill
  // and in_ready drops.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle  <= 0;
      hold_left <= 0;
      ready_pat <= '1;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (rx_cycle == 600 || rx_cycle == 2200) begin
        hold_left <= LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        if (rx_cycle % 64 == 0) begin
          ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
        end
        out_ready <= ready_pat[rx_cycle % 16];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checker: each transaction on out_ is compared with the oldest expectation.
  // ---------------------------------------------------------------------------------------
  task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%0t: mismatch on %s, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    gsalu_pkg::out_item_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("%0t: result transaction with nothing expected: %h", $time, out_data);
        end
      end else begin
        due = pending_results.pop_front();
        if (out_data.result !== due.result)
          flag_field("result", due.result, out_data.result);
        if (out_data.writes_dest !== due.writes_dest)
          flag_field("writes_dest", 64'(due.writes_dest), 64'(out_data.writes_dest));
        if (out_data.scc_out !== due.scc_out)
          flag_field("scc_out", 64'(due.scc_out), 64'(out_data.scc_out));
        if (out_data.exec_out !== due.exec_out)
          flag_field("exec_out", due.exec_out, out_data.exec_out);
        if (out_data.unsupported !== due.unsupported)
          flag_field("unsupported", 64'(due.unsupported), 64'(out_data.unsupported));
      end
    end
  end

  // Watchdog: gives up after a long run of cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
design/gsalu_pkg.sv
design/gsalu_alu.sv
design/gpu_scalar_alu_with_scc.sv
design/gsalu_chk.sv
sim/gpu_scalar_alu_with_scc_test.sv
